// ===== rtl/polyline_length_accumulator_top_macros.svh =====
// Assertion helpers for the polyline length block
`ifndef POLYLINE_LENGTH_ACCUMULATOR_TOP_MACROS_SVH
`define POLYLINE_LENGTH_ACCUMULATOR_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define PLA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define PLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pla_pkg.sv =====
package pla_pkg;

  // port field widths
  localparam int PT_W  = 16;
  localparam int LEN_W = 48;
  localparam int CNT_W = 16;

  // arithmetic configuration
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 8;

  // derived datapath widths
  localparam int MAG_W  = COORD_WIDTH;
  localparam int SQ_W   = 2 * MAG_W + 1;
  localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int PAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 3;
  localparam int STEP_W = $clog2(ROOT_W + 1);
  localparam int SUM_W  = ((ROOT_W > LEN_W) ? ROOT_W : LEN_W) + 1;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last_point;
  } pla_in_t;

  typedef struct packed {
    logic [LEN_W-1:0] total_length;
    logic [CNT_W-1:0] point_count;
    logic             length_saturated;
  } pla_out_t;

  // square root unit request and response
  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } pla_sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } pla_sqrt_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQS,
    ST_SRT,
    ST_WAIT,
    ST_ACC,
    ST_EMIT
  } pla_state_e;

  // low COORD_WIDTH bits of a port coordinate, sign-extended
  function automatic logic signed [COORD_WIDTH-1:0] sext_coord(logic signed [PT_W-1:0] v);
    logic signed [COORD_WIDTH-1:0] r;
    for (int i = 0; i < COORD_WIDTH; i++) begin
      r[i] = v[(i < PT_W) ? i : PT_W - 1];
    end
    return r;
  endfunction

endpackage

// ===== rtl/polyline_length_accumulator_top.sv =====
// Channel  Direction  Handshake               Beat
// in       input      in_valid_i / in_stall_o    pla_in_t  (point_x, point_y, last_point)
// out      output     out_valid_o / out_stall_i  pla_out_t (total_length, point_count,
//                                                           length_saturated)
//
// A point after the first of its polyline goes through states SQX, SQY, SQS, SRT, WAIT
// and ACC: the squares go through one shared multiplier, then the segment root runs one
// bit per cycle in the compare-subtract unit. A first point goes straight to ACC; a last
// point goes on to EMIT to load the output register. The result register lets the next
// point in while a result waits under out_stall_i; a last point then waits for it.
// rst_ni clears the polyline state and drops out_valid_o.
module polyline_length_accumulator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pla_pkg::pla_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pla_pkg::pla_out_t out_data_o
);
  import pla_pkg::*;

  pla_state_e state_q, state_d;

  // polyline state
  logic signed [COORD_WIDTH-1:0] prev_x_q, prev_y_q;
  logic                          have_prev_q;
  logic [LEN_W-1:0]              len_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          sat_q;

  // per-point working registers
  logic [MAG_W-1:0]   ax_q, ay_q;
  logic               last_q;
  logic               seg_en_q;
  logic [2*MAG_W-1:0] prod_q;
  logic [SQ_W-1:0]    sq_q;

  // result register
  pla_out_t out_q;
  logic     out_valid_q;

  // sequencer outputs
  logic in_acc;
  logic mul_sel_y;
  logic acc_en;
  logic emit_go;
  logic out_free;

  pla_sqrt_req_t sqrt_req;
  pla_sqrt_rsp_t sqrt_rsp;

  // coordinate differences and magnitudes
  logic signed [COORD_WIDTH-1:0] x_c, y_c;
  logic signed [COORD_WIDTH:0]   dx, dy, dx_neg, dy_neg;
  logic [MAG_W-1:0]              ax_d, ay_d;

  assign x_c    = sext_coord(in_data_i.point_x);
  assign y_c    = sext_coord(in_data_i.point_y);
  assign dx     = {x_c[COORD_WIDTH-1], x_c} - {prev_x_q[COORD_WIDTH-1], prev_x_q};
  assign dy     = {y_c[COORD_WIDTH-1], y_c} - {prev_y_q[COORD_WIDTH-1], prev_y_q};
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign ax_d   = dx[COORD_WIDTH] ? dx_neg[MAG_W-1:0] : dx[MAG_W-1:0];
  assign ay_d   = dy[COORD_WIDTH] ? dy_neg[MAG_W-1:0] : dy[MAG_W-1:0];

  // shared squarer
  logic [MAG_W-1:0]   mul_a;
  logic [2*MAG_W-1:0] prod;

  assign mul_a = mul_sel_y ? ay_q : ax_q;
  assign prod  = mul_a * mul_a;

  // saturating length sum
  logic [SUM_W-1:0] len_sum;
  logic             len_ovf;

  assign len_sum = SUM_W'(len_q) + SUM_W'(sqrt_rsp.root);
  assign len_ovf = (len_sum > SUM_W'(LEN_MAX));

  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = have_prev_q ? ST_SQX : ST_ACC;
        end
      end
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQS;
      ST_SQS:  state_d = ST_SRT;
      ST_SRT:  state_d = ST_WAIT;
      ST_WAIT: begin
        if (sqrt_rsp.done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC:  state_d = last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o        = 1'b1;
    mul_sel_y         = 1'b0;
    acc_en            = 1'b0;
    emit_go           = 1'b0;
    sqrt_req.start    = 1'b0;
    sqrt_req.radicand = {sq_q, {(2*FRAC_BITS){1'b0}}};
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_SQY:  mul_sel_y = 1'b1;
      ST_SRT:  sqrt_req.start = 1'b1;
      ST_ACC:  acc_en = 1'b1;
      ST_EMIT: emit_go = out_free;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && !in_stall_o;

  pla_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  // sequencer state and polyline state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
      len_q       <= '0;
      cnt_q       <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        prev_x_q    <= x_c;
        prev_y_q    <= y_c;
        have_prev_q <= 1'b1;
        if (cnt_q != CNT_MAX) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (acc_en && seg_en_q) begin
        if (len_ovf) begin
          len_q <= LEN_MAX;
          sat_q <= 1'b1;
        end else begin
          len_q <= len_sum[LEN_W-1:0];
        end
      end
      // result goes out, polyline starts over
      if (emit_go) begin
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        have_prev_q <= 1'b0;
        len_q       <= '0;
        cnt_q       <= '0;
        sat_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      last_q   <= in_data_i.last_point;
      seg_en_q <= have_prev_q;
    end
    if (state_q == ST_SQX || state_q == ST_SQY) begin
      prod_q <= prod;
    end
    if (state_q == ST_SQY) begin
      sq_q <= SQ_W'(prod_q);
    end else if (state_q == ST_SQS) begin
      sq_q <= sq_q + SQ_W'(prod_q);
    end
    if (emit_go) begin
      out_q.total_length     <= len_q;
      out_q.point_count      <= cnt_q;
      out_q.length_saturated <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pla_isqrt.sv =====
module pla_isqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pla_pkg::pla_sqrt_req_t req_i,
  output pla_pkg::pla_sqrt_rsp_t rsp_o
);
  import pla_pkg::*;

  logic [PAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // one root bit per step: bring down two radicand bits, try to subtract
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[PAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rad_d  = PAD_W'(req_i.radicand);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = STEP_W'(ROOT_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = rad_q << 2;
      rem_d  = fits ? (rem_sh - trial) : rem_sh;
      root_d = {root_q[ROOT_W-2:0], fits};
      cnt_d  = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // sequencing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

// ===== rtl/pla_checker.sv =====
`include "polyline_length_accumulator_top_macros.svh"

module pla_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input pla_pkg::pla_out_t out_data_o
);
  import pla_pkg::*;

  logic in_beat;
  logic out_held;
  logic out_sat;
  logic len_full;
  logic cnt_zero;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_sat  = out_valid_o && out_data_o.length_saturated;
  assign len_full = (out_data_o.total_length == LEN_MAX);
  assign cnt_zero = (out_data_o.point_count == '0);

  // a stalled result keeps its contents
  `PLA_ASSERT_NEXT(a_out_hold, out_held, out_valid_o && $stable(out_data_o), "result changed")

  // a point keeps the block busy for at least the next cycle
  `PLA_ASSERT_NEXT(a_busy_after_beat, in_beat, in_stall_o, "ready right after a point beat")

  // a saturated length is the all-ones value
  `PLA_ASSERT_NOW(a_sat_max, out_sat, len_full, "saturated length below maximum")

  // every polyline has at least one point
  `PLA_ASSERT_NOW(a_count_nonzero, out_valid_o, !cnt_zero, "result with zero points")

endmodule

bind polyline_length_accumulator_top pla_checker u_pla_checker (.*);
